FILE: hdl/bpd_pkg.sv
// bpd_pkg: shared types, codes and constants of the bitmap pixel row decoder
// used by bpd_row_tracker, bmp_pixel_row_decoder and the testbench
`default_nettype none

package bpd_pkg;

	// default sizes
	localparam int PALETTE_DEPTH_DEF = 256;
	localparam int MAX_WIDTH_DEF     = 4096;

	// register field widths and limits
	localparam int BPP_W         = 6;
	localparam int DIM_W         = 13;
	localparam int DIM_REG_MAX   = (1 << DIM_W) - 1;
	localparam int HEIGHT_MAX    = 4096;
	localparam int ROW_W         = 12;
	localparam int POS_OUT_W     = 12;
	localparam int PIX_CNT_W     = 4;

	// request opcodes
	localparam logic [1:0] OP_PALETTE = 2'd0;
	localparam logic [1:0] OP_PIXEL   = 2'd1;
	localparam logic [1:0] OP_START   = 2'd2;

	// supported pixel depths
	localparam logic [BPP_W-1:0] BPP_1  = 6'd1;
	localparam logic [BPP_W-1:0] BPP_4  = 6'd4;
	localparam logic [BPP_W-1:0] BPP_8  = 6'd8;
	localparam logic [BPP_W-1:0] BPP_16 = 6'd16;
	localparam logic [BPP_W-1:0] BPP_24 = 6'd24;
	localparam logic [BPP_W-1:0] BPP_32 = 6'd32;

	// register map, index = paddr[3:2]
	localparam int APB_AW = 4;
	localparam logic [1:0] REG_BPP    = 2'd0;
	localparam logic [1:0] REG_WIDTH  = 2'd1;
	localparam logic [1:0] REG_HEIGHT = 2'd2;

	// where a pixel's colour comes from
	typedef enum logic [1:0] {
		SRC_PAL1   = 2'd0,
		SRC_PAL4   = 2'd1,
		SRC_PAL8   = 2'd2,
		SRC_DIRECT = 2'd3
	} src_t;

	// one data byte's worth of pixels, handed from the row tracker to the issue stage
	typedef struct packed {
		src_t                 mode;
		logic [PIX_CNT_W-1:0] count;
		logic                 ends_row;
		logic                 ends_image;
		logic [ROW_W-1:0]     row;
		logic [7:0]           data;
		logic [31:0]          direct;
	} job_t;

	// largest effective width for a given size limit
	function automatic int eff_width_max(input int max_width);
		return (max_width < DIM_REG_MAX) ? max_width : DIM_REG_MAX;
	endfunction

endpackage

`default_nettype wire

FILE: hdl/bpd_palette_ram.sv
// bpd_palette_ram: BGRA palette store, one write port and one registered read port
// depends on nothing; read returns the old entry when written in the same cycle
`default_nettype none

module bpd_palette_ram #(
	parameter int DEPTH = 256,
	parameter int AW    = 8
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [31:0]   wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr,
	output logic      [31:0]   rdata
);

	logic [31:0] mem [DEPTH];
	logic [31:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, data held while no read is enabled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

FILE: hdl/bpd_row_tracker.sv
// bpd_row_tracker: byte, column and row counters, pixel assembly and row padding skip
// depends on bpd_pkg; turns each accepted data byte that yields pixels into a pixel job
`default_nettype none

module bpd_row_tracker #(
	parameter int MAX_WIDTH = bpd_pkg::MAX_WIDTH_DEF,
	parameter int COL_W     = $clog2(bpd_pkg::eff_width_max(MAX_WIDTH) + 1)
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         accept,
	input  wire logic [1:0]                   opcode,
	input  wire logic [7:0]                   data_byte,
	input  wire logic [bpd_pkg::BPP_W-1:0]    cfg_bpp,
	input  wire logic [bpd_pkg::DIM_W-1:0]    cfg_width,
	input  wire logic [bpd_pkg::DIM_W-1:0]    cfg_height,
	output logic                              job_go,
	output bpd_pkg::job_t                     job,
	output logic      [COL_W-1:0]             base_col
);

	localparam int EFFW_MAX = bpd_pkg::eff_width_max(MAX_WIDTH);
	localparam int BROW_W   = $clog2(4 * EFFW_MAX + 1);
	localparam int LEN_W    = BROW_W + 1;

	logic [23:0]                    asm_q;
	logic [1:0]                     bip_q;
	logic [BROW_W-1:0]              bir_q;
	logic [COL_W-1:0]               col_q;
	logic [bpd_pkg::ROW_W-1:0]      row_q;
	logic                           done_q;

	logic [COL_W-1:0]               w_eff;
	logic [bpd_pkg::DIM_W-1:0]      h_eff;
	logic [LEN_W-1:0]               wz;
	logic [LEN_W-1:0]               len;
	logic [LEN_W-1:0]               stride;
	logic [LEN_W-1:0]               bir_inc;
	logic                           supported;
	bpd_pkg::src_t                  mode;
	logic [2:0]                     nb;
	logic [bpd_pkg::PIX_CNT_W-1:0]  per_byte;
	logic                           in_data;
	logic                           direct_fire;
	logic [31:0]                    c;
	logic [31:0]                    px;
	logic [23:0]                    asm_next;
	logic [COL_W-1:0]               room;
	logic [bpd_pkg::PIX_CNT_W-1:0]  k;
	logic [bpd_pkg::PIX_CNT_W-1:0]  n;
	logic [COL_W-1:0]               col_next;
	logic                           ends_row;
	logic                           ends_image;
	logic                           row_end;
	logic                           pixel_req;

	// effective size, zero counts as one
	always_comb begin
		if (cfg_width == '0) begin
			w_eff = COL_W'(1);
		end else if (int'(cfg_width) > MAX_WIDTH) begin
			w_eff = COL_W'(EFFW_MAX);
		end else begin
			w_eff = COL_W'(cfg_width);
		end
		if (cfg_height == '0) begin
			h_eff = bpd_pkg::DIM_W'(1);
		end else if (cfg_height > bpd_pkg::DIM_W'(bpd_pkg::HEIGHT_MAX)) begin
			h_eff = bpd_pkg::DIM_W'(bpd_pkg::HEIGHT_MAX);
		end else begin
			h_eff = cfg_height;
		end
	end

	// depth decode and data bytes per row
	always_comb begin
		wz        = LEN_W'(w_eff);
		supported = 1'b1;
		mode      = bpd_pkg::SRC_DIRECT;
		nb        = 3'd1;
		per_byte  = bpd_pkg::PIX_CNT_W'(1);
		len       = wz;
		unique case (cfg_bpp)
			bpd_pkg::BPP_1: begin
				mode     = bpd_pkg::SRC_PAL1;
				per_byte = bpd_pkg::PIX_CNT_W'(8);
				len      = (wz + LEN_W'(7)) >> 3;
			end
			bpd_pkg::BPP_4: begin
				mode     = bpd_pkg::SRC_PAL4;
				per_byte = bpd_pkg::PIX_CNT_W'(2);
				len      = (wz + LEN_W'(1)) >> 1;
			end
			bpd_pkg::BPP_8: begin
				mode = bpd_pkg::SRC_PAL8;
			end
			bpd_pkg::BPP_16: begin
				nb  = 3'd2;
				len = wz << 1;
			end
			bpd_pkg::BPP_24: begin
				nb  = 3'd3;
				len = (wz << 1) + wz;
			end
			bpd_pkg::BPP_32: begin
				nb  = 3'd4;
				len = wz << 2;
			end
			default: begin
				supported = 1'b0;
			end
		endcase
		stride  = (len + LEN_W'(3)) & ~LEN_W'(3);
		bir_inc = LEN_W'(bir_q) + LEN_W'(1);
		in_data = LEN_W'(bir_q) < len;
		row_end = bir_inc >= stride;
	end

	// little-endian assembly of multi-byte pixels
	always_comb begin
		direct_fire = ({1'b0, bip_q} + 3'd1) >= nb;
		asm_next    = asm_q | (24'(data_byte) << {bip_q, 3'b000});
		c           = {8'h00, asm_q};
		px          = c;
		case (nb)
			3'd2: begin
				c  = {8'h00, asm_q} | {16'h0000, data_byte, 8'h00};
				px = {8'hff, c[14:10], 3'b000, c[9:5], 3'b000, c[4:0], 3'b000};
			end
			3'd3: begin
				c  = {8'h00, asm_q} | {8'h00, data_byte, 16'h0000};
				px = {8'hff, c[23:0]};
			end
			default: begin
				c  = {data_byte, asm_q};
				px = c;
			end
		endcase
	end

	// pixels this byte emits, clipped at the image width
	always_comb begin
		if (!in_data) begin
			k = '0;
		end else if (mode == bpd_pkg::SRC_DIRECT) begin
			k = direct_fire ? bpd_pkg::PIX_CNT_W'(1) : '0;
		end else begin
			k = per_byte;
		end
		room = w_eff - col_q;
		if (col_q >= w_eff) begin
			n = '0;
		end else if (room < COL_W'(k)) begin
			n = bpd_pkg::PIX_CNT_W'(room);
		end else begin
			n = k;
		end
		col_next   = col_q + COL_W'(n);
		ends_row   = (n != '0) && (col_next == w_eff);
		ends_image = ends_row &&
			((bpd_pkg::DIM_W'(row_q) + bpd_pkg::DIM_W'(1)) >= h_eff);
	end

	assign pixel_req = accept && (opcode == bpd_pkg::OP_PIXEL) && supported && !done_q;

	// counter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			asm_q  <= '0;
			bip_q  <= '0;
			bir_q  <= '0;
			col_q  <= '0;
			row_q  <= '0;
			done_q <= 1'b0;
		end else if (accept && (opcode == bpd_pkg::OP_START)) begin
			asm_q  <= '0;
			bip_q  <= '0;
			bir_q  <= '0;
			col_q  <= '0;
			row_q  <= '0;
			done_q <= 1'b0;
		end else if (pixel_req) begin
			if (ends_image) begin
				done_q <= 1'b1;
			end
			if (row_end) begin
				asm_q <= '0;
				bip_q <= '0;
				bir_q <= '0;
				col_q <= '0;
				row_q <= row_q + bpd_pkg::ROW_W'(1);
			end else begin
				bir_q <= BROW_W'(bir_inc);
				col_q <= col_next;
				if (in_data && (mode == bpd_pkg::SRC_DIRECT)) begin
					if (direct_fire) begin
						asm_q <= '0;
						bip_q <= '0;
					end else begin
						asm_q <= asm_next;
						bip_q <= bip_q + 2'd1;
					end
				end
			end
		end
	end

	// job for the issue stage
	assign job_go          = pixel_req && (n != '0);
	assign base_col        = col_q;
	assign job.mode        = mode;
	assign job.count       = n;
	assign job.ends_row    = ends_row;
	assign job.ends_image  = ends_image;
	assign job.row         = row_q;
	assign job.data        = data_byte;
	assign job.direct      = px;

endmodule

`default_nettype wire

FILE: hdl/bmp_pixel_row_decoder.sv
// bmp_pixel_row_decoder: top level, register port, job stage, palette read and output register
// depends on bpd_pkg, bpd_row_tracker and bpd_palette_ram
// a request's first pixel passes the job stage, the read stage and the output register
// throughput: one pixel per cycle while pix_ready is high, set by the single palette read
//   port; one request per cycle at 8 to 32 bpp, at 1 and 4 bpp once all its pixels issue
// reset: counters, valids and registers return to their reset values at once; the
//   palette is not cleared and holds nothing meaningful until written
`default_nettype none

module bmp_pixel_row_decoder #(
	parameter int PALETTE_DEPTH = bpd_pkg::PALETTE_DEPTH_DEF,
	parameter int MAX_WIDTH     = bpd_pkg::MAX_WIDTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// register port
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [bpd_pkg::APB_AW-1:0]    paddr,
	input  wire logic [31:0]                   pwdata,
	output logic      [31:0]                   prdata,
	output logic                               pready,
	// request channel
	input  wire logic                          req_valid,
	output logic                               req_ready,
	input  wire logic [1:0]                    opcode,
	input  wire logic [7:0]                    palette_index,
	input  wire logic [7:0]                    palette_blue,
	input  wire logic [7:0]                    palette_green,
	input  wire logic [7:0]                    palette_red,
	input  wire logic [7:0]                    palette_alpha,
	input  wire logic [7:0]                    data_byte,
	// pixel channel
	output logic                               pix_valid,
	input  wire logic                          pix_ready,
	output logic      [7:0]                    red,
	output logic      [7:0]                    green,
	output logic      [7:0]                    blue,
	output logic      [7:0]                    alpha,
	output logic      [bpd_pkg::POS_OUT_W-1:0] pixel_column,
	output logic      [bpd_pkg::POS_OUT_W-1:0] pixel_row,
	output logic                               last_of_byte,
	output logic                               end_of_row,
	output logic                               end_of_image
);

	localparam int COL_W  = $clog2(bpd_pkg::eff_width_max(MAX_WIDTH) + 1);
	localparam int PAL_AW = $clog2(PALETTE_DEPTH);

	logic [bpd_pkg::BPP_W-1:0]     cfg_bpp_q;
	logic [bpd_pkg::DIM_W-1:0]     cfg_width_q;
	logic [bpd_pkg::DIM_W-1:0]     cfg_height_q;

	logic                          req_accept;
	logic                          job_go;
	bpd_pkg::job_t                 job_new;
	logic [COL_W-1:0]              base_col;

	logic                          job_valid_s1;
	bpd_pkg::job_t                 job_s1;
	logic [COL_W-1:0]              col_s1;
	logic [2:0]                    pix_s1;

	logic                          s2_free;
	logic                          s2_adv;
	logic                          issue;
	logic                          last_issue;
	logic [7:0]                    pal_idx;
	logic                          use_pal;
	logic                          pal_in_range;
	logic                          pal_we;
	logic                          pal_re;
	logic [31:0]                   pal_rdata;

	logic                          valid_s2;
	logic                          use_pal_s2;
	logic                          zero_s2;
	logic [31:0]                   direct_s2;
	logic [COL_W-1:0]              col_s2;
	logic [bpd_pkg::ROW_W-1:0]     row_s2;
	logic                          last_s2;
	logic                          eor_s2;
	logic                          eoi_s2;

	logic                          out_valid_q;
	logic [31:0]                   out_bgra_q;
	logic [bpd_pkg::POS_OUT_W-1:0] out_col_q;
	logic [bpd_pkg::POS_OUT_W-1:0] out_row_q;
	logic                          out_last_q;
	logic                          out_eor_q;
	logic                          out_eoi_q;
	logic [31:0]                   color_s2;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_bpp_q    <= bpd_pkg::BPP_24;
			cfg_width_q  <= bpd_pkg::DIM_W'(1);
			cfg_height_q <= bpd_pkg::DIM_W'(1);
		end else if (psel && penable && pwrite) begin
			unique case (paddr[3:2])
				bpd_pkg::REG_BPP:    cfg_bpp_q    <= pwdata[bpd_pkg::BPP_W-1:0];
				bpd_pkg::REG_WIDTH:  cfg_width_q  <= pwdata[bpd_pkg::DIM_W-1:0];
				bpd_pkg::REG_HEIGHT: cfg_height_q <= pwdata[bpd_pkg::DIM_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// register reads
	always_comb begin
		unique case (paddr[3:2])
			bpd_pkg::REG_BPP:    prdata = 32'(cfg_bpp_q);
			bpd_pkg::REG_WIDTH:  prdata = 32'(cfg_width_q);
			bpd_pkg::REG_HEIGHT: prdata = 32'(cfg_height_q);
			default:             prdata = '0;
		endcase
	end

	assign pready = 1'b1;

	// ready chain from the output register back to the request side
	assign s2_adv     = valid_s2 && (!out_valid_q || pix_ready);
	assign s2_free    = !valid_s2 || s2_adv;
	assign issue      = job_valid_s1 && s2_free;
	assign last_issue = ({1'b0, pix_s1} + bpd_pkg::PIX_CNT_W'(1)) == job_s1.count;
	assign req_ready  = !job_valid_s1 || (issue && last_issue);
	assign req_accept = req_valid && req_ready;

	bpd_row_tracker #(
		.MAX_WIDTH (MAX_WIDTH),
		.COL_W     (COL_W)
	) u_tracker (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (req_accept),
		.opcode     (opcode),
		.data_byte  (data_byte),
		.cfg_bpp    (cfg_bpp_q),
		.cfg_width  (cfg_width_q),
		.cfg_height (cfg_height_q),
		.job_go     (job_go),
		.job        (job_new),
		.base_col   (base_col)
	);

	// job stage, one pixel handed on per issue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_valid_s1 <= 1'b0;
			pix_s1       <= '0;
		end else if (req_accept) begin
			job_valid_s1 <= job_go;
			pix_s1       <= '0;
		end else if (issue) begin
			if (last_issue) begin
				job_valid_s1 <= 1'b0;
			end
			pix_s1 <= pix_s1 + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (req_accept && job_go) begin
			job_s1 <= job_new;
			col_s1 <= base_col;
		end
	end

	// palette index of the pixel being issued, bits taken msb first
	always_comb begin
		pal_idx = '0;
		use_pal = 1'b1;
		unique case (job_s1.mode)
			bpd_pkg::SRC_PAL1:   pal_idx = {7'b0, job_s1.data[~pix_s1]};
			bpd_pkg::SRC_PAL4:   pal_idx = pix_s1[0] ? {4'b0, job_s1.data[3:0]}
			                                         : {4'b0, job_s1.data[7:4]};
			bpd_pkg::SRC_PAL8:   pal_idx = job_s1.data;
			bpd_pkg::SRC_DIRECT: use_pal = 1'b0;
			default:             use_pal = 1'b0;
		endcase
		pal_in_range = {1'b0, pal_idx} < 9'(PALETTE_DEPTH);
	end

	// palette port; a write in the cycle of an earlier byte's last read still
	// leaves that read with the old entry
	assign pal_we = req_accept && (opcode == bpd_pkg::OP_PALETTE) &&
		({1'b0, palette_index} < 9'(PALETTE_DEPTH));
	assign pal_re = issue && use_pal && pal_in_range;

	bpd_palette_ram #(
		.DEPTH (PALETTE_DEPTH),
		.AW    (PAL_AW)
	) u_palette (
		.clk   (clk),
		.we    (pal_we),
		.waddr (palette_index[PAL_AW-1:0]),
		.wdata ({palette_alpha, palette_red, palette_green, palette_blue}),
		.re    (pal_re),
		.raddr (pal_idx[PAL_AW-1:0]),
		.rdata (pal_rdata)
	);

	// read stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (issue) begin
			valid_s2 <= 1'b1;
		end else if (s2_adv) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			use_pal_s2 <= use_pal;
			zero_s2    <= use_pal && !pal_in_range;
			direct_s2  <= job_s1.direct;
			col_s2     <= col_s1 + COL_W'(pix_s1);
			row_s2     <= job_s1.row;
			last_s2    <= last_issue;
			eor_s2     <= last_issue && job_s1.ends_row;
			eoi_s2     <= last_issue && job_s1.ends_image;
		end
	end

	// colour select
	always_comb begin
		if (zero_s2) begin
			color_s2 = '0;
		end else if (use_pal_s2) begin
			color_s2 = pal_rdata;
		end else begin
			color_s2 = direct_s2;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s2_adv) begin
			out_valid_q <= 1'b1;
		end else if (pix_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_adv) begin
			out_bgra_q <= color_s2;
			out_col_q  <= bpd_pkg::POS_OUT_W'(col_s2);
			out_row_q  <= bpd_pkg::POS_OUT_W'(row_s2);
			out_last_q <= last_s2;
			out_eor_q  <= eor_s2;
			out_eoi_q  <= eoi_s2;
		end
	end

	assign pix_valid    = out_valid_q;
	assign blue         = out_bgra_q[7:0];
	assign green        = out_bgra_q[15:8];
	assign red          = out_bgra_q[23:16];
	assign alpha        = out_bgra_q[31:24];
	assign pixel_column = out_col_q;
	assign pixel_row    = out_row_q;
	assign last_of_byte = out_last_q;
	assign end_of_row   = out_eor_q;
	assign end_of_image = out_eoi_q;

endmodule

`default_nettype wire

FILE: test/testbench.sv
// testbench: self-checking bench for bmp_pixel_row_decoder; directed table, then random images
// depends on bpd_pkg and the bmp_pixel_row_decoder rtl; predicts pixels from its own model
// of the palette, byte assembly, row stride and image counters, or from a checked table step
`default_nettype none

module testbench;
	import bpd_pkg::*;

	localparam logic [1:0]       OP_IGNORED      = 2'd3;
	localparam logic [BPP_W-1:0] BPP_UNSUPPORTED = 6'd5;
	localparam int               QUIET_LIMIT     = 2000;
	localparam int               SETTLE_CYCLES   = 16;
	localparam int               TOTAL_ITEMS     = 360;
	localparam int               ERROR_PRINTS    = 50;

	typedef struct packed {
		logic [1:0] opcode;
		logic [7:0] index;
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
		logic [7:0] alpha;
		logic [7:0] data;
	} request_t;

	typedef struct packed {
		logic [7:0]           red;
		logic [7:0]           green;
		logic [7:0]           blue;
		logic [7:0]           alpha;
		logic [POS_OUT_W-1:0] column;
		logic [POS_OUT_W-1:0] row;
		logic                 last_of_byte;
		logic                 end_of_row;
		logic                 end_of_image;
	} pixel_t;

	typedef pixel_t pixel_list_t[$];

	typedef enum logic {STEP_CONFIG, STEP_REQUEST} step_kind_t;

	typedef struct {
		step_kind_t       kind;
		logic [BPP_W-1:0] bpp;
		logic [DIM_W-1:0] width;
		logic [DIM_W-1:0] height;
		request_t         req;
		bit               typed;
		pixel_t           pix;
	} step_t;

	// dut signals
	logic                 clk;
	logic                 arst_n;
	logic                 psel;
	logic                 penable;
	logic                 pwrite;
	logic [APB_AW-1:0]    paddr;
	logic [31:0]          pwdata;
	logic [31:0]          prdata;
	logic                 pready;
	logic                 req_valid;
	logic                 req_ready;
	logic [1:0]           opcode;
	logic [7:0]           palette_index;
	logic [7:0]           palette_blue;
	logic [7:0]           palette_green;
	logic [7:0]           palette_red;
	logic [7:0]           palette_alpha;
	logic [7:0]           data_byte;
	logic                 pix_valid;
	logic                 pix_ready;
	logic [7:0]           red;
	logic [7:0]           green;
	logic [7:0]           blue;
	logic [7:0]           alpha;
	logic [POS_OUT_W-1:0] pixel_column;
	logic [POS_OUT_W-1:0] pixel_row;
	logic                 last_of_byte;
	logic                 end_of_row;
	logic                 end_of_image;

	// decoder model state
	logic [BPP_W-1:0] cfg_bpp    = BPP_24;
	logic [DIM_W-1:0] cfg_width  = 1;
	logic [DIM_W-1:0] cfg_height = 1;
	logic [31:0]      palette_copy [256];
	logic [23:0]      partial_pixel = '0;
	int unsigned      pixel_byte    = 0;
	int unsigned      row_byte      = 0;
	int unsigned      column_idx    = 0;
	int unsigned      row_idx       = 0;
	bit               image_done    = 0;

	// bookkeeping
	pixel_t      expected_pixels [$];
	step_t       plan [$];
	int          error_count   = 0;
	int          pixel_count   = 0;
	int          request_count = 0;
	int          image_count   = 0;
	int          phase_count   = 0;
	int          quiet_cycles  = 0;
	int          req_calm      = 0;
	int          pix_calm      = 0;

	bmp_pixel_row_decoder i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.req_valid    (req_valid),
		.req_ready    (req_ready),
		.opcode       (opcode),
		.palette_index(palette_index),
		.palette_blue (palette_blue),
		.palette_green(palette_green),
		.palette_red  (palette_red),
		.palette_alpha(palette_alpha),
		.data_byte    (data_byte),
		.pix_valid    (pix_valid),
		.pix_ready    (pix_ready),
		.red          (red),
		.green        (green),
		.blue         (blue),
		.alpha        (alpha),
		.pixel_column (pixel_column),
		.pixel_row    (pixel_row),
		.last_of_byte (last_of_byte),
		.end_of_row   (end_of_row),
		.end_of_image (end_of_image)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// ---------------------------------------------------------------- model

	function automatic bit depth_supported(input logic [BPP_W-1:0] bpp);
		return bpp inside {BPP_1, BPP_4, BPP_8, BPP_16, BPP_24, BPP_32};
	endfunction

	function automatic int unsigned eff_width();
		if (cfg_width == 0) return 1;
		if (cfg_width > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
		return cfg_width;
	endfunction

	function automatic int unsigned eff_height();
		if (cfg_height == 0) return 1;
		if (cfg_height > HEIGHT_MAX) return HEIGHT_MAX;
		return cfg_height;
	endfunction

	// data bytes per row, padding included
	function automatic int unsigned stride_bytes();
		int unsigned len;
		len = (eff_width() * int'(cfg_bpp) + 7) / 8;
		return (len + 3) & ~32'd3;
	endfunction

	function automatic void clear_row();
		partial_pixel = '0;
		pixel_byte    = 0;
		row_byte      = 0;
		column_idx    = 0;
	endfunction

	// append one pixel unless the image is done, the column is past the width or eight are produced
	task automatic emit_pixel(input logic [31:0] bgra, ref pixel_list_t produced);
		pixel_t      p;
		int unsigned w;
		int unsigned h;
		w = eff_width();
		h = eff_height();
		if (image_done || column_idx >= w || produced.size() >= 8) return;
		p.red          = bgra[23:16];
		p.green        = bgra[15:8];
		p.blue         = bgra[7:0];
		p.alpha        = bgra[31:24];
		p.column       = column_idx[POS_OUT_W-1:0];
		p.row          = row_idx[POS_OUT_W-1:0];
		p.last_of_byte = 1'b0;
		p.end_of_row   = (column_idx + 1 == w);
		p.end_of_image = p.end_of_row && (row_idx + 1 >= h);
		produced.push_back(p);
		column_idx++;
		if (p.end_of_image) image_done = 1;
	endtask

	// pixels caused by one accepted request
	task automatic decode_request(input request_t r, ref pixel_list_t produced);
		int unsigned nbytes;
		logic [31:0] word;
		logic [31:0] colour;
		pixel_t      tail;
		produced = {};
		case (r.opcode)
			OP_PALETTE: palette_copy[r.index] = {r.alpha, r.red, r.green, r.blue};
			OP_START: begin
				clear_row();
				row_idx    = 0;
				image_done = 0;
			end
			OP_PIXEL: if (depth_supported(cfg_bpp) && !image_done) begin
				if (row_byte < (eff_width() * int'(cfg_bpp) + 7) / 8) begin
					case (cfg_bpp)
						BPP_1: for (int k = 7; k >= 0; k--)
							emit_pixel(palette_copy[{7'd0, r.data[k]}], produced);
						BPP_4: begin
							emit_pixel(palette_copy[{4'd0, r.data[7:4]}], produced);
							emit_pixel(palette_copy[{4'd0, r.data[3:0]}], produced);
						end
						BPP_8: emit_pixel(palette_copy[r.data], produced);
						default: begin
							// direct colour, bytes assembled little endian
							nbytes = int'(cfg_bpp) / 8;
							if (pixel_byte + 1 < nbytes) begin
								partial_pixel = 24'(32'(partial_pixel)
									| (32'(r.data) << (8 * pixel_byte)));
								pixel_byte = (pixel_byte + 1) & 3;
							end else begin
								word = 32'(partial_pixel)
									| (32'(r.data) << (8 * ((nbytes - 1) & 3)));
								partial_pixel = '0;
								pixel_byte    = 0;
								case (cfg_bpp)
									BPP_16: colour = {8'hff, word[14:10], 3'b000,
										word[9:5], 3'b000, word[4:0], 3'b000};
									BPP_24: colour = {8'hff, word[23:0]};
									default: colour = word;
								endcase
								emit_pixel(colour, produced);
							end
						end
					endcase
				end
				// row padding and row advance
				row_byte++;
				if (row_byte >= stride_bytes()) begin
					clear_row();
					row_idx = (row_idx + 1) & 12'hfff;
				end
			end
			default: ;
		endcase
		if (produced.size() > 0) begin
			tail = produced.pop_back();
			tail.last_of_byte = 1'b1;
			produced.push_back(tail);
		end
	endtask

	// ---------------------------------------------------------------- stimulus helpers

	function automatic request_t make_request(input logic [1:0] op, input logic [7:0] idx,
			input logic [7:0] b, input logic [7:0] g, input logic [7:0] r,
			input logic [7:0] a, input logic [7:0] d);
		request_t q;
		q = '{opcode: op, index: idx, blue: b, green: g, red: r, alpha: a, data: d};
		return q;
	endfunction

	function automatic request_t random_request(input logic [1:0] op);
		return make_request(op, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
			8'($urandom), 8'($urandom));
	endfunction

	function automatic pixel_t typed_pixel(input logic [7:0] r, input logic [7:0] g,
			input logic [7:0] b, input logic [7:0] a, input int col, input int row,
			input logic eor, input logic eoi);
		pixel_t p;
		p = '{red: r, green: g, blue: b, alpha: a, column: col[POS_OUT_W-1:0],
			row: row[POS_OUT_W-1:0], last_of_byte: 1'b1, end_of_row: eor, end_of_image: eoi};
		return p;
	endfunction

	function automatic step_t config_step(input logic [BPP_W-1:0] bpp,
			input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
		step_t s;
		s = '{kind: STEP_CONFIG, bpp: bpp, width: w, height: h, req: '0, typed: 0, pix: '0};
		return s;
	endfunction

	function automatic step_t command_step(input logic [1:0] op, input logic [7:0] idx,
			input logic [7:0] b, input logic [7:0] g, input logic [7:0] r, input logic [7:0] a);
		step_t s;
		s = '{kind: STEP_REQUEST, bpp: '0, width: '0, height: '0,
			req: make_request(op, idx, b, g, r, a, 8'h00), typed: 0, pix: '0};
		return s;
	endfunction

	function automatic step_t data_step(input logic [7:0] d);
		step_t s;
		s = '{kind: STEP_REQUEST, bpp: '0, width: '0, height: '0,
			req: make_request(OP_PIXEL, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, d),
			typed: 0, pix: '0};
		return s;
	endfunction

	function automatic step_t checked_step(input logic [7:0] d, input pixel_t p);
		step_t s;
		s = data_step(d);
		s.typed = 1;
		s.pix   = p;
		return s;
	endfunction

	// per-item wait with occasional stretches of none
	function automatic int draw_wait(ref int calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 24) == 0) begin
			calm = $urandom_range(10, 40);
			return 0;
		end
		return ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 17);
	endfunction

	// ---------------------------------------------------------------- drivers

	// one request on the request channel; predicted at the accepting edge
	task automatic send_request(input request_t r, input bit typed, input pixel_t want);
		int          gap;
		pixel_list_t produced;
		gap = draw_wait(req_calm);
		@(negedge clk);
		if (gap > 0) begin
			req_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		{opcode, palette_index, palette_blue, palette_green, palette_red, palette_alpha,
			data_byte} = r;
		req_valid = 1'b1;
		do @(posedge clk); while (!req_ready);
		request_count++;
		decode_request(r, produced);
		if (typed) expected_pixels.push_back(want);
		else foreach (produced[i]) expected_pixels.push_back(produced[i]);
	endtask

	task automatic write_register(input logic [1:0] reg_index, input logic [31:0] value);
		@(negedge clk);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = {reg_index, 2'b00};
		pwdata  = value;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		case (reg_index)
			REG_BPP:    cfg_bpp    = value[BPP_W-1:0];
			REG_WIDTH:  cfg_width  = value[DIM_W-1:0];
			REG_HEIGHT: cfg_height = value[DIM_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
	endtask

	// drain outstanding pixels, let the pipeline empty, then set all three registers
	task automatic configure(input logic [BPP_W-1:0] bpp, input logic [DIM_W-1:0] w,
			input logic [DIM_W-1:0] h);
		@(negedge clk);
		req_valid = 1'b0;
		while (expected_pixels.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		write_register(REG_BPP, 32'(bpp));
		write_register(REG_WIDTH, 32'(w));
		write_register(REG_HEIGHT, 32'(h));
		phase_count++;
	endtask

	// pixel sink with random stalls
	initial begin
		int stall;
		pix_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = draw_wait(pix_calm);
			@(negedge clk);
			if (stall > 0) begin
				pix_ready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			pix_ready = 1'b1;
			do @(posedge clk); while (!pix_valid);
		end
	end

	// ---------------------------------------------------------------- checking

	task automatic note_error(input string msg);
		if (error_count < ERROR_PRINTS) $display("mismatch: %s", msg);
		error_count++;
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want)
			note_error($sformatf("pixel %0d: %s is %0h, expected %0h", pixel_count, name,
				got, want));
	endtask

	// compare every accepted pixel with the oldest prediction
	always @(posedge clk) begin : pixel_monitor
		pixel_t seen;
		pixel_t want;
		if (arst_n && pix_valid && pix_ready) begin
			seen = {red, green, blue, alpha, pixel_column, pixel_row, last_of_byte,
				end_of_row, end_of_image};
			if (expected_pixels.size() == 0) begin
				note_error($sformatf("pixel %0d at column %0d row %0d was not expected",
					pixel_count, pixel_column, pixel_row));
			end else begin
				want = expected_pixels.pop_front();
				check_field("red", 32'(seen.red), 32'(want.red));
				check_field("green", 32'(seen.green), 32'(want.green));
				check_field("blue", 32'(seen.blue), 32'(want.blue));
				check_field("alpha", 32'(seen.alpha), 32'(want.alpha));
				check_field("pixel_column", 32'(seen.column), 32'(want.column));
				check_field("pixel_row", 32'(seen.row), 32'(want.row));
				check_field("last_of_byte", 32'(seen.last_of_byte), 32'(want.last_of_byte));
				check_field("end_of_row", 32'(seen.end_of_row), 32'(want.end_of_row));
				check_field("end_of_image", 32'(seen.end_of_image), 32'(want.end_of_image));
			end
			if (seen.end_of_image === 1'b1) image_count++;
			pixel_count++;
		end
	end

	// watchdog on cycles with no transfer on any port
	always @(posedge clk) begin
		if ((req_valid && req_ready) || (pix_valid && pix_ready) || (psel && penable))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("timeout: no transfer for %0d cycles, %0d pixels still expected",
				quiet_cycles, expected_pixels.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// ---------------------------------------------------------------- main sequence

	initial begin
		logic [BPP_W-1:0] depths [6];
		logic [BPP_W-1:0] bpp;
		logic [DIM_W-1:0] w;
		logic [DIM_W-1:0] h;
		int unsigned      total;
		int               noise;
		depths = '{BPP_1, BPP_4, BPP_8, BPP_16, BPP_24, BPP_32};

		// every input known from the start, reset asserted first and then released
		arst_n    = 1'b0;
		psel      = 1'b0;
		penable   = 1'b0;
		pwrite    = 1'b0;
		paddr     = '0;
		pwdata    = '0;
		req_valid = 1'b0;
		{opcode, palette_index, palette_blue, palette_green, palette_red, palette_alpha,
			data_byte} = '0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		// directed table: reset settings, image end, palette depths, direct depths, clamps
		plan.push_back(data_step(8'h00));
		plan.push_back(data_step(8'h80));
		plan.push_back(checked_step(8'hff, typed_pixel(8'hff, 8'h80, 8'h00, 8'hff, 0, 0, 1, 1)));
		plan.push_back(data_step(8'h55));
		plan.push_back(command_step(OP_IGNORED, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
		plan.push_back(command_step(OP_PALETTE, 8'd0, 8'h00, 8'h00, 8'h00, 8'h00));
		plan.push_back(command_step(OP_PALETTE, 8'd1, 8'hff, 8'hff, 8'hff, 8'hff));
		plan.push_back(command_step(OP_PALETTE, 8'd15, 8'h12, 8'h34, 8'h56, 8'h78));
		plan.push_back(command_step(OP_PALETTE, 8'd255, 8'haa, 8'hbb, 8'hcc, 8'hdd));
		plan.push_back(config_step(BPP_1, 13'd9, 13'd2));
		plan.push_back(command_step(OP_START, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
		plan.push_back(data_step(8'haa));
		plan.push_back(checked_step(8'h80, typed_pixel(8'hff, 8'hff, 8'hff, 8'hff, 8, 0, 1, 0)));
		plan.push_back(data_step(8'h00));
		plan.push_back(data_step(8'hff));
		plan.push_back(data_step(8'h7f));
		plan.push_back(checked_step(8'h01, typed_pixel(8'h00, 8'h00, 8'h00, 8'h00, 8, 1, 1, 1)));
		plan.push_back(config_step(BPP_4, 13'd3, 13'h1fff));
		plan.push_back(command_step(OP_START, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
		plan.push_back(data_step(8'h0f));
		plan.push_back(checked_step(8'hf0, typed_pixel(8'h56, 8'h34, 8'h12, 8'h78, 2, 0, 1, 0)));
		plan.push_back(config_step(BPP_16, 13'd0, 13'd0));
		plan.push_back(command_step(OP_START, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
		plan.push_back(data_step(8'hff));
		plan.push_back(checked_step(8'h7f, typed_pixel(8'hf8, 8'hf8, 8'hf8, 8'hff, 0, 0, 1, 1)));
		plan.push_back(config_step(BPP_32, 13'h1fff, 13'd1));
		plan.push_back(command_step(OP_START, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
		plan.push_back(data_step(8'h01));
		plan.push_back(data_step(8'h02));
		plan.push_back(data_step(8'h03));
		plan.push_back(checked_step(8'hff, typed_pixel(8'h03, 8'h02, 8'h01, 8'hff, 0, 0, 0, 0)));
		plan.push_back(config_step(BPP_8, 13'd2, 13'd1));
		plan.push_back(command_step(OP_START, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
		plan.push_back(data_step(8'hff));
		plan.push_back(checked_step(8'h01, typed_pixel(8'hff, 8'hff, 8'hff, 8'hff, 1, 0, 1, 1)));
		plan.push_back(config_step(BPP_UNSUPPORTED, 13'd4, 13'd1));
		plan.push_back(data_step(8'h12));

		foreach (plan[i]) begin
			if (plan[i].kind == STEP_CONFIG)
				configure(plan[i].bpp, plan[i].width, plan[i].height);
			else
				send_request(plan[i].req, plan[i].typed, plan[i].pix);
		end

		// fill the whole palette so that any index byte is legal from here on
		for (int i = 0; i < 256; i++) begin
			send_request(make_request(OP_PALETTE, 8'(i), 8'($urandom), 8'($urandom),
				8'($urandom), 8'($urandom), 8'h00), 0, '0);
		end

		// random images until the request budget is spent
		while (request_count < TOTAL_ITEMS) begin
			if ($urandom_range(0, 9) == 0) begin
				do bpp = BPP_W'($urandom_range(0, 63)); while (depth_supported(bpp));
			end else begin
				bpp = depths[$urandom_range(0, 5)];
			end
			if ($urandom_range(0, 11) == 0) begin
				case ($urandom_range(0, 3))
					0: w = 13'd0;
					1: w = 13'(MAX_WIDTH_DEF);
					2: w = 13'h1fff;
					default: w = 13'($urandom_range(MAX_WIDTH_DEF + 1, DIM_REG_MAX - 1));
				endcase
			end else begin
				w = 13'($urandom_range(1, 12));
			end
			case ($urandom_range(0, 29))
				0: h = 13'd0;
				1: h = 13'(HEIGHT_MAX);
				2: h = 13'h1fff;
				default: h = 13'($urandom_range(1, 3));
			endcase
			configure(bpp, w, h);

			// now and then carry on mid-image under the new settings
			if ($urandom_range(0, 5) != 0) begin
				send_request(random_request(OP_START), 0, '0);
			end

			if (!depth_supported(cfg_bpp)) total = $urandom_range(2, 6);
			else if (stride_bytes() * eff_height() <= 96)
				total = stride_bytes() * eff_height() + $urandom_range(0, 3);
			else total = $urandom_range(8, 40);

			for (int unsigned j = 0; j < total && request_count < TOTAL_ITEMS; j++) begin
				// occasional noise: palette rewrite, ignored opcode, broken image
				noise = $urandom_range(0, 19);
				if (noise == 0) begin
					send_request(random_request(OP_PALETTE), 0, '0);
				end else if (noise == 1) begin
					send_request(random_request(OP_IGNORED), 0, '0);
				end else if (noise == 2 && $urandom_range(0, 3) == 0) begin
					send_request(random_request(OP_START), 0, '0);
				end
				send_request(random_request(OP_PIXEL), 0, '0);
			end
		end

		// drain and let the pipeline run dry
		@(negedge clk);
		req_valid = 1'b0;
		while (expected_pixels.size() != 0) @(posedge clk);
		repeat (24) @(posedge clk);

		$display("%0d requests over %0d register settings gave %0d pixels", request_count,
			phase_count, pixel_count);
		$display("%0d images ran to their last pixel", image_count);
		if (error_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("%0d mismatches", error_count);
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

`default_nettype wire

FILE: sim.f
hdl/bpd_pkg.sv
hdl/bpd_palette_ram.sv
hdl/bpd_row_tracker.sv
hdl/bmp_pixel_row_decoder.sv
test/testbench.sv
